// ===== sv/gas_pkg.sv =====
// Shared types and codes for the grid next-step search block.
package gas_pkg;

    // Row length of the grid; cell index is y*GRID_W + x, so the column sits in the low bits
    localparam int GRID_W = 64;

    localparam logic [2:0] DIR_STOP  = 3'd0;
    localparam logic [2:0] DIR_LEFT  = 3'd1;
    localparam logic [2:0] DIR_RIGHT = 3'd2;
    localparam logic [2:0] DIR_UP    = 3'd3;
    localparam logic [2:0] DIR_DOWN  = 3'd4;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Neighbour codes as stored in the parent table
    localparam logic [1:0] NB_LEFT  = 2'd0;
    localparam logic [1:0] NB_RIGHT = 2'd1;
    localparam logic [1:0] NB_UP    = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    // Command handed from the front end to the search engine
    typedef struct packed {
        logic       is_query;
        logic [7:0] sx;
        logic [7:0] sy;
        logic       wall;
        logic [7:0] gx;
        logic [7:0] gy;
        logic       bad;
    } gas_cmd_t;

endpackage

// ===== sv/gas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gas_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/gas_front.sv =====
// Front end: takes input transactions, range-checks them and fills a small queue.
module gas_front #(
    parameter int GRID_H = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [21:0]      in_data,
    output logic             q_valid,
    input  logic             q_pop,
    output gas_pkg::gas_cmd_t q_cmd
);
    import gas_pkg::*;

    gas_cmd_t   cmd;
    gas_cmd_t   fifo_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       push;

    // Unpack and classify
    always_comb begin
        cmd.is_query = in_data[0];
        cmd.sx       = {2'b0, in_data[6:1]};
        cmd.sy       = {4'b0, in_data[10:7]};
        cmd.wall     = in_data[11];
        cmd.gx       = {2'b0, in_data[17:12]};
        cmd.gy       = {4'b0, in_data[21:18]};
        cmd.bad      = (32'(cmd.sx) >= GRID_W) || (32'(cmd.sy) >= GRID_H)
                     || (cmd.is_query && ((32'(cmd.gx) >= GRID_W)
                     || (32'(cmd.gy) >= GRID_H)));
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = fifo_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !q_pop) cnt_next = cnt_reg + 2'd1;
        if (!push && q_pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (q_pop) rd_reg <= ~rd_reg;
        end
        if (push) fifo_reg[wr_reg] <= cmd;
    end
endmodule

// ===== sv/gas_engine.sv =====
// Search engine: wall map writes, clearing, open-set scan, expansion, walk back.
module gas_engine #(
    parameter int GRID_H = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_pop,
    input  gas_pkg::gas_cmd_t q_cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [2:0]       res_dir,
    output logic             res_status
);
    import gas_pkg::*;

    localparam int NC = GRID_W * GRID_H;
    localparam int AW = $clog2(NC);
    localparam int XW = $clog2(GRID_W);
    localparam int YW = $clog2(GRID_H);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_SCANW = 4'd4;
    localparam logic [3:0] S_PICK  = 4'd5;
    localparam logic [3:0] S_NRD   = 4'd6;
    localparam logic [3:0] S_NUPD  = 4'd7;
    localparam logic [3:0] S_WALK  = 4'd8;
    localparam logic [3:0] S_WALKW = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_BRD   = 4'd11;

    logic [3:0]    st_reg;
    logic [AW:0]   idx_reg;
    logic [AW-1:0] s_reg, g_reg, best_reg, c_reg;
    logic [XW-1:0] gx_reg;
    logic [YW-1:0] gy_reg;
    logic          found_reg;
    logic [11:0]   bestf_reg;
    logic [9:0]    bestg_reg;
    logic [2:0]    k_reg;
    logic [2:0]    dir_reg;
    logic          stat_reg;
    logic [AW-1:0] scan_a_reg;
    logic          scan_v_reg;
    logic [AW:0]   guard_reg;

    // Memory ports
    logic          w_we, o_we, c_we, p_we, d_we;
    logic [AW-1:0] w_wa, o_wa, c_wa, p_wa, d_wa;
    logic [AW-1:0] w_ra, o_ra, c_ra, p_ra, d_ra;
    logic          w_wd, o_wd, c_wd, w_rd, o_rd, c_rd;
    logic [9:0]    p_wd, p_rd;
    logic [1:0]    d_wd, d_rd;

    gas_ram #(.WIDTH(1),  .DEPTH(NC)) u_wall (.aclk, .we(w_we), .waddr(w_wa), .wdata(w_wd),
        .raddr(w_ra), .rdata(w_rd));
    gas_ram #(.WIDTH(1),  .DEPTH(NC)) u_open (.aclk, .we(o_we), .waddr(o_wa), .wdata(o_wd),
        .raddr(o_ra), .rdata(o_rd));
    gas_ram #(.WIDTH(1),  .DEPTH(NC)) u_clsd (.aclk, .we(c_we), .waddr(c_wa), .wdata(c_wd),
        .raddr(c_ra), .rdata(c_rd));
    gas_ram #(.WIDTH(10), .DEPTH(NC)) u_cost (.aclk, .we(p_we), .waddr(p_wa), .wdata(p_wd),
        .raddr(p_ra), .rdata(p_rd));
    gas_ram #(.WIDTH(2),  .DEPTH(NC)) u_par  (.aclk, .we(d_we), .waddr(d_wa), .wdata(d_wd),
        .raddr(d_ra), .rdata(d_rd));

    // Neighbour of the expanded cell
    logic [XW-1:0] bx, nxv;
    logic [YW-1:0] by, nyv;
    logic          n_ok;
    logic [AW-1:0] n_addr;
    always_comb begin
        bx = best_reg[XW-1:0];
        by = YW'(best_reg / GRID_W);
        nxv = bx;
        nyv = by;
        n_ok = 1'b1;
        case (k_reg[1:0])
            NB_LEFT:  begin n_ok = (bx != '0); nxv = bx - 1'b1; end
            NB_RIGHT: begin n_ok = (32'(bx) != GRID_W-1); nxv = bx + 1'b1; end
            NB_UP:    begin n_ok = (by != '0); nyv = by - 1'b1; end
            default:  begin n_ok = (32'(by) != GRID_H-1); nyv = by + 1'b1; end
        endcase
        n_addr = AW'(32'(nyv) * GRID_W + 32'(nxv));
    end

    // Heuristic of the scanned cell
    logic [XW-1:0] sxc;
    logic [YW-1:0] syc;
    logic [11:0]   hval, fval;
    always_comb begin
        sxc = scan_a_reg[XW-1:0];
        syc = YW'(scan_a_reg / GRID_W);
        hval = 12'(sxc > gx_reg ? sxc - gx_reg : gx_reg - sxc)
             + 12'(syc > gy_reg ? syc - gy_reg : gy_reg - syc);
        fval = 12'(p_rd) + hval;
    end

    // Parent of the walk cursor
    logic [AW:0] par;
    always_comb begin
        unique case (d_rd)
            NB_LEFT:  par = {1'b0, c_reg} + 1'b1;
            NB_RIGHT: par = {1'b0, c_reg} - 1'b1;
            NB_UP:    par = {1'b0, c_reg} + (AW+1)'(GRID_W);
            default:  par = {1'b0, c_reg} - (AW+1)'(GRID_W);
        endcase
    end

    logic [9:0] ng;
    assign ng = bestg_reg + 10'd1;

    assign q_pop      = (st_reg == S_IDLE) && q_valid;
    assign res_valid  = (st_reg == S_OUT);
    assign res_dir    = dir_reg;
    assign res_status = stat_reg;

    // Memory control
    always_comb begin
        w_we = 1'b0; w_wa = q_cmd.sy[YW-1:0] * AW'(GRID_W) + AW'(q_cmd.sx[XW-1:0]);
        w_wd = q_cmd.wall;
        o_we = 1'b0; o_wa = idx_reg[AW-1:0]; o_wd = 1'b0;
        c_we = 1'b0; c_wa = idx_reg[AW-1:0]; c_wd = 1'b0;
        p_we = 1'b0; p_wa = n_addr; p_wd = ng;
        d_we = 1'b0; d_wa = n_addr; d_wd = k_reg[1:0];
        w_ra = n_addr; o_ra = n_addr; c_ra = n_addr; p_ra = n_addr;
        d_ra = c_reg;
        case (st_reg)
            S_INIT: begin
                w_we = 1'b1; w_wa = idx_reg[AW-1:0]; w_wd = 1'b0;
            end
            S_IDLE: w_we = q_pop && !q_cmd.is_query && !q_cmd.bad;
            S_CLR: begin
                o_we = 1'b1; c_we = 1'b1;
                if (idx_reg[AW-1:0] == s_reg) o_wd = 1'b1;
                p_we = (idx_reg[AW-1:0] == s_reg); p_wa = s_reg; p_wd = '0;
            end
            S_SCAN: begin
                o_ra = idx_reg[AW-1:0]; p_ra = idx_reg[AW-1:0];
            end
            S_PICK: begin
                o_we = 1'b1; o_wa = best_reg; o_wd = 1'b0;
                c_we = 1'b1; c_wa = best_reg; c_wd = 1'b1;
            end
            S_NUPD: begin
                if (n_ok && !w_rd && !c_rd && (!o_rd || ng < p_rd)) begin
                    o_we = 1'b1; o_wa = n_addr; o_wd = 1'b1;
                    p_we = 1'b1; d_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= S_INIT;
            idx_reg    <= '0;
            scan_v_reg <= 1'b0;
        end else begin
            scan_v_reg <= 1'b0;
            unique case (st_reg)
                S_INIT: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg[AW-1:0] == AW'(NC-1)) st_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (q_pop && q_cmd.is_query) begin
                        s_reg  <= AW'(32'(q_cmd.sy) * GRID_W + 32'(q_cmd.sx));
                        g_reg  <= AW'(32'(q_cmd.gy) * GRID_W + 32'(q_cmd.gx));
                        gx_reg <= q_cmd.gx[XW-1:0];
                        gy_reg <= q_cmd.gy[YW-1:0];
                        dir_reg  <= DIR_STOP;
                        stat_reg <= 1'b1;
                        idx_reg  <= '0;
                        if (q_cmd.bad) st_reg <= S_OUT;
                        else if (q_cmd.sx == q_cmd.gx && q_cmd.sy == q_cmd.gy) begin
                            stat_reg <= 1'b0;
                            st_reg   <= S_OUT;
                        end else st_reg <= S_CLR;
                    end
                end
                S_CLR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg[AW-1:0] == AW'(NC-1)) begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        st_reg    <= S_SCAN;
                    end
                end
                // Stream every cell through the read ports, compare one a cycle
                S_SCAN: begin
                    scan_a_reg <= idx_reg[AW-1:0];
                    scan_v_reg <= 1'b1;
                    idx_reg    <= idx_reg + 1'b1;
                    if (idx_reg[AW-1:0] == AW'(NC-1)) st_reg <= S_SCANW;
                end
                S_SCANW: begin
                    st_reg <= S_BRD;
                end
                S_BRD: begin
                    if (!found_reg) st_reg <= S_OUT;
                    else st_reg <= S_PICK;
                end
                S_PICK: begin
                    if (best_reg == g_reg) begin
                        c_reg     <= g_reg;
                        guard_reg <= '0;
                        st_reg    <= S_WALK;
                    end else begin
                        k_reg  <= '0;
                        st_reg <= S_NRD;
                    end
                end
                S_NRD: st_reg <= S_NUPD;
                S_NUPD: begin
                    if (k_reg == 3'd3) begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        st_reg    <= S_SCAN;
                    end else begin
                        k_reg  <= k_reg + 1'b1;
                        st_reg <= S_NRD;
                    end
                end
                S_WALK: st_reg <= S_WALKW;
                S_WALKW: begin
                    guard_reg <= guard_reg + 1'b1;
                    if (32'(par) >= NC) st_reg <= S_OUT;
                    else if (par[AW-1:0] == s_reg) begin
                        dir_reg  <= {1'b0, d_rd} + 3'd1;
                        stat_reg <= 1'b0;
                        st_reg   <= S_OUT;
                    end else if (32'(guard_reg) == NC-1) st_reg <= S_OUT;
                    else begin
                        c_reg  <= par[AW-1:0];
                        st_reg <= S_WALK;
                    end
                end
                S_OUT: if (res_ready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
            // Running minimum over the scanned open cells
            if (scan_v_reg && o_rd && (!found_reg || fval < bestf_reg)) begin
                found_reg <= 1'b1;
                bestf_reg <= fval;
                best_reg  <= scan_a_reg;
                bestg_reg <= p_rd;
            end
        end
    end
endmodule

// ===== sv/grid_astar_next_step.sv =====
// Top level of the grid next-step path search block.
//  channel | dir | fields (tdata low bit up)                         | tuser
//  s_      | in  | req_type, cell_x, cell_y, wall, goal_x, goal_y     | -
//  m_      | out | direction, status                                 | -
// A map write is done in the idle state as it leaves the queue. A query clears the
// open/closed flags one cell a cycle, then each expansion scans all cells for the open
// cell of lowest cost plus Manhattan distance and updates its neighbours; the walk back
// follows the parent codes. After reset the wall map is cleared, one cell a cycle.
// A two-entry queue takes transactions while the engine works; a result waits for
// m_axis_tready, and s_axis_tready drops once the queue holds two transactions.
module grid_astar_next_step #(
    parameter int GRID_H = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // req_type, cell_x, cell_y, wall, goal_x, goal_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // direction, status
);
    import gas_pkg::*;

    logic     q_valid, q_pop;
    gas_cmd_t q_cmd;
    logic [2:0] dir;
    logic       stat;

    gas_front #(.GRID_H(GRID_H)) u_front (
        .aclk, .aresetn, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata[21:0]), .q_valid, .q_pop, .q_cmd);

    gas_engine #(.GRID_H(GRID_H)) u_engine (
        .aclk, .aresetn, .q_valid, .q_pop, .q_cmd,
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_dir(dir), .res_status(stat));

    assign m_axis_tdata = {4'b0, stat, dir};
endmodule

// ===== tb/tb_grid_astar_next_step.sv =====
// Self-checking testbench for the grid next-step path search block.
module tb_grid_astar_next_step;
    import gas_pkg::*;

    localparam int W      = 64;
    localparam int H      = 16;
    localparam int NCELL  = W * H;
    localparam int LIMIT  = 600_000_000;
    localparam int HOLD   = 20_000;
    localparam int MAXEXP = 40;

    typedef struct {
        logic [2:0] dir;
        logic       nopath;
    } step_t;

    // Scoreboard: keeps a copy of the wall map and the expected step results
    class step_scoreboard;
        bit          walls [NCELL];
        bit          open_c [NCELL];
        bit          shut_c [NCELL];
        int          cost [NCELL];
        logic [1:0]  from_nb [NCELL];
        step_t       pending_steps [$];
        int          errors, n_writes, n_queries, n_results, n_nopath;

        // A* search on the current map; nexp counts expansions, cut off above cap
        function void search(int sx, int sy, int gx, int gy, int cap,
                             output step_t r, output int nexp);
            int s, g, best, bestf, f, cx, cy, nx, ny, n, c, p, hx, hy;
            bit found;
            r.dir    = DIR_STOP;
            r.nopath = 1'b1;
            nexp     = 0;
            s = sy * W + sx;
            g = gy * W + gx;
            if (s == g) begin
                r.nopath = 1'b0;
                return;
            end
            for (int i = 0; i < NCELL; i++) begin
                open_c[i] = 0;
                shut_c[i] = 0;
            end
            open_c[s] = 1;
            cost[s]   = 0;
            forever begin
                found = 0;
                best  = 0;
                bestf = 0;
                for (int i = 0; i < NCELL; i++) begin
                    if (open_c[i]) begin
                        hx = (i % W) > gx ? (i % W) - gx : gx - (i % W);
                        hy = (i / W) > gy ? (i / W) - gy : gy - (i / W);
                        f  = cost[i] + hx + hy;
                        if (!found || f < bestf) begin
                            found = 1;
                            best  = i;
                            bestf = f;
                        end
                    end
                end
                if (!found) return;
                nexp++;
                if (nexp > cap) return;
                open_c[best] = 0;
                shut_c[best] = 1;
                if (best == g) break;
                cx = best % W;
                cy = best / W;
                for (int k = 0; k < 4; k++) begin
                    nx = cx + (k == NB_LEFT ? -1 : k == NB_RIGHT ? 1 : 0);
                    ny = cy + (k == NB_UP ? -1 : k == NB_DOWN ? 1 : 0);
                    if (nx < 0 || ny < 0 || nx >= W || ny >= H) continue;
                    n = ny * W + nx;
                    if (walls[n] || shut_c[n]) continue;
                    if (!open_c[n] || cost[best] + 1 < cost[n]) begin
                        open_c[n]  = 1;
                        cost[n]    = (cost[best] + 1) & 1023;
                        from_nb[n] = k[1:0];
                    end
                end
            end
            // trace parents back to the cell next to the start
            c = g;
            for (int guard = 0; guard < NCELL; guard++) begin
                case (from_nb[c])
                    NB_LEFT:  p = c + 1;
                    NB_RIGHT: p = c - 1;
                    NB_UP:    p = c + W;
                    default:  p = c - W;
                endcase
                if (p < 0 || p >= NCELL) return;
                if (p == s) begin
                    case (from_nb[c])
                        NB_LEFT:  r.dir = DIR_LEFT;
                        NB_RIGHT: r.dir = DIR_RIGHT;
                        NB_UP:    r.dir = DIR_UP;
                        default:  r.dir = DIR_DOWN;
                    endcase
                    r.nopath = 1'b0;
                    return;
                end
                c = p;
            end
        endfunction

        // Accepted input transaction: update map or queue the expected step
        function void note_item(logic [23:0] d);
            step_t r;
            int    nexp;
            if (d[0] == REQ_WRITE) begin
                walls[d[10:7] * W + d[6:1]] = d[11];
                n_writes++;
            end else begin
                search(int'(d[6:1]), int'(d[10:7]), int'(d[17:12]), int'(d[21:18]),
                       NCELL + 1, r, nexp);
                pending_steps.push_back(r);
                n_queries++;
                if (r.nopath) n_nopath++;
            end
        endfunction

        // Accepted result transaction: compare with the oldest expectation
        function void check_result(logic [7:0] d);
            step_t e;
            n_results++;
            if (pending_steps.size() == 0) begin
                $display("%0t: unexpected result dir=%0d status=%0d", $time, d[2:0], d[3]);
                errors++;
                return;
            end
            e = pending_steps.pop_front();
            if (d[2:0] !== e.dir) begin
                $display("%0t: direction mismatch expected %0d actual %0d",
                         $time, e.dir, d[2:0]);
                errors++;
            end
            if (d[3] !== e.nopath) begin
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, e.nopath, d[3]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    step_scoreboard sb = new();
    int  snd_idle = 0;
    int  rcv_idle = 0;
    bit  hold_tog = 0;
    bit  hold_seen = 0;
    int  hold_left = 0;
    int  cycles = 0;

    grid_astar_next_step u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Input monitor: feed accepted transactions to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata);
    end

    // Result side: check accepted results, random stalls, long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            hold_seen <= hold_tog;
            if (hold_tog != hold_seen) begin
                hold_left     <= HOLD;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    function automatic logic [23:0] pack(logic r, int x, int y, logic w, int gx, int gy);
        logic [5:0] px, pgx;
        logic [3:0] py, pgy;
        px  = 6'(x);
        py  = 4'(y);
        pgx = 6'(gx);
        pgy = 4'(gy);
        return {2'b00, pgy, pgx, w, py, px, r};
    endfunction

    // Offer one transaction and wait until it is taken
    task automatic send(logic [23:0] d);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wr(int x, int y, logic w);
        send(pack(REQ_WRITE, x, y, w, $urandom_range(63), $urandom_range(15)));
    endtask

    task automatic qry(int x, int y, int gx, int gy);
        send(pack(REQ_QUERY, x, y, 1'($urandom_range(1)), gx, gy));
    endtask

    // Sender pause until every expected step has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_steps.size() != 0) @(posedge aclk);
    endtask

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Local window: a few wall edits then a query of bounded search effort
    task automatic local_burst(ref int items);
        int    cx, cy, sx, sy, gx, gy, nexp, tries;
        step_t r;
        cx = $urandom_range(W - 1);
        cy = $urandom_range(H - 1);
        repeat ($urandom_range(3)) begin
            wr(clampi(cx + $urandom_range(4) - 2, 0, W - 1),
               clampi(cy + $urandom_range(4) - 2, 0, H - 1), 1'($urandom_range(1)));
            items++;
        end
        if ($urandom_range(9) == 0) begin
            wr($urandom_range(W - 1), $urandom_range(H - 1), 1'($urandom_range(1)));
            items++;
        end
        // the last write may not be in the map copy yet; this only steers the query choice
        tries = 0;
        do begin
            sx = clampi(cx + $urandom_range(4) - 2, 0, W - 1);
            sy = clampi(cy + $urandom_range(4) - 2, 0, H - 1);
            gx = clampi(cx + $urandom_range(4) - 2, 0, W - 1);
            gy = clampi(cy + $urandom_range(4) - 2, 0, H - 1);
            sb.search(sx, sy, gx, gy, MAXEXP, r, nexp);
            tries++;
        end while (nexp > MAXEXP && tries < 30);
        if (nexp > MAXEXP) begin
            gx = sx;
            gy = sy;
        end
        qry(sx, sy, gx, gy);
        items++;
    endtask

    initial begin
        int items;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of the fields and the special cases
        wr(0, 0, 1'b1);
        qry(0, 0, 0, 0);           // start equals goal on a walled cell
        qry(0, 0, 1, 0);           // walled start is left normally
        wr(63, 15, 1'b1);
        wr(61, 15, 1'b1);
        wr(62, 14, 1'b1);
        qry(62, 15, 63, 15);       // walled goal, boxed start: no path
        wr(61, 15, 1'b0);
        wr(62, 14, 1'b0);
        wr(63, 15, 1'b0);
        qry(62, 15, 63, 15);       // right
        qry(63, 15, 63, 14);       // up
        qry(63, 14, 63, 15);       // down
        qry(10, 5, 9, 5);          // left
        qry(63, 0, 63, 1);
        wr(31, 8, 1'b1);
        qry(30, 8, 32, 8);         // detour around a wall
        wr(31, 8, 1'b0);
        wr(0, 0, 1'b0);
        drain();

        // Random phases with changing idle mix
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle = (ph == 0) ? 13 : (ph == 1) ? 80 : 0;
            rcv_idle = (ph == 0) ? 80 : (ph == 1) ? 13 : 0;
            items = 0;
            if (ph == 2) begin
                // long receiver hold while cheap queries keep coming
                hold_tog <= ~hold_tog;
                for (int i = 0; i < 6; i++) begin
                    qry(20 + i, 3, 21 + i, 3);
                    items++;
                end
            end
            while (items < 40) local_burst(items);
            drain();
        end

        repeat (200) @(posedge aclk);
        $display("Covered %0d map writes and %0d queries, %0d of them without a path.",
                 sb.n_writes, sb.n_queries, sb.n_nopath);
        $display("Checked %0d results with %0d mismatches.", sb.n_results, sb.errors);
        if (sb.errors == 0 && sb.pending_steps.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
